[sv/pnr_pkg.sv]
package pnr_pkg;

    localparam int Q_W        = 48;
    localparam int FRAC_W     = 24;
    localparam int IT_W       = 6;
    localparam int TOL_W      = 24;
    localparam int DIV_STEPS  = Q_W + FRAC_W;
    localparam int DSTEP_W    = $clog2(DIV_STEPS + 1);
    localparam int DEF_MAX_DEGREE = 8;

    // apb register map
    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;
    localparam logic [1:0] REG_MAX_IT = 2'd0;
    localparam logic [1:0] REG_TOL    = 2'd1;
    localparam logic [1:0] REG_START  = 2'd2;

    localparam logic [IT_W-1:0]  RST_MAX_IT = IT_W'(30);
    localparam logic [TOL_W-1:0] RST_TOL    = TOL_W'(2);

    localparam logic signed [Q_W-1:0] MAXPOS = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] MAXNEG = {1'b1, {(Q_W-1){1'b0}}};

    typedef logic signed [Q_W-1:0] t_q;

    typedef struct packed {
        logic done;
        t_q   quot;
    } t_div_rsp;

    function automatic logic [Q_W-1:0] f_mag(input t_q v);
        return v[Q_W-1] ? (Q_W'(0) - v) : v;
    endfunction

    // magnitude plus sign back to a saturated signed value
    function automatic t_q f_apply(input logic [Q_W+2:0] m, input logic neg);
        if (neg) begin
            if (m >= (Q_W+3)'({1'b1, {(Q_W-1){1'b0}}})) return MAXNEG;
            return Q_W'(0) - m[Q_W-1:0];
        end
        if (m > (Q_W+3)'(MAXPOS)) return MAXPOS;
        return m[Q_W-1:0];
    endfunction

    function automatic t_q f_sat49(input logic [Q_W:0] v);
        if (!v[Q_W] && v[Q_W-1]) return MAXPOS;
        if (v[Q_W] && !v[Q_W-1]) return MAXNEG;
        return v[Q_W-1:0];
    endfunction

endpackage

[sv/pnr_coef_if.sv]
interface pnr_coef_if;
    import pnr_pkg::*;
    logic valid;
    logic ready;
    t_q   coefficient;
    logic coefficient_last;
    modport source(output valid, coefficient, coefficient_last, input ready);
    modport sink(input valid, coefficient, coefficient_last, output ready);
endinterface

[sv/pnr_root_if.sv]
interface pnr_root_if;
    import pnr_pkg::*;
    logic            valid;
    logic            ready;
    t_q              root_value;
    logic [IT_W-1:0] iterations_used;
    logic            converged;
    logic            divide_fault;
    logic            root_last;
    modport source(output valid, root_value, iterations_used, converged, divide_fault,
                   root_last, input ready);
    modport sink(input valid, root_value, iterations_used, converged, divide_fault,
                 root_last, output ready);
endinterface

[sv/pnr_div.sv]
module pnr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  pnr_pkg::t_q       i_num,
    input  pnr_pkg::t_q       i_den,
    output pnr_pkg::t_div_rsp o_rsp
);
    import pnr_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DSTEP_W-1:0]   r_cnt;
    logic [DIV_STEPS-1:0] r_dvd;
    logic [Q_W-1:0]       r_rem;
    logic [Q_W:0]         r_q;
    logic [Q_W-1:0]       r_md;
    logic                 r_over;
    logic                 r_neg;
    t_q                   r_quot;

    logic [Q_W:0] w_rem_sh;
    logic         w_ge;
    logic [Q_W:0] w_qsat;

    assign w_rem_sh = {r_rem, r_dvd[DIV_STEPS-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_md};
    assign w_qsat   = (r_over || r_q[Q_W]) ? {1'b1, {Q_W{1'b0}}} : r_q;

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DSTEP_W'(DIV_STEPS);
                r_dvd  <= {f_mag(i_num), {FRAC_W{1'b0}}};
                r_rem  <= '0;
                r_q    <= '0;
                r_over <= 1'b0;
                r_md   <= f_mag(i_den);
                r_neg  <= i_num[Q_W-1] ^ i_den[Q_W-1];
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_quot <= f_apply({2'b0, w_qsat}, r_neg);
                end else begin
                    r_cnt  <= r_cnt - 1'b1;
                    r_dvd  <= {r_dvd[DIV_STEPS-2:0], 1'b0};
                    r_over <= r_over | r_q[Q_W];
                    r_q    <= {r_q[Q_W-1:0], w_ge};
                    r_rem  <= w_ge ? Q_W'(w_rem_sh - {1'b0, r_md}) : w_rem_sh[Q_W-1:0];
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

[sv/polynomial_newton_root_finder_core.sv]
// polynomial root finder, newton iteration with horner synthetic division
// coefficients arrive on i_coef, lowest power first, one transaction per cycle
// while loading; the transaction with coefficient_last set starts the solve.
// beyond MAX_DEGREE+1 coefficients the extra ones are dropped.
// one result transaction per root leaves on o_root, highest degree first,
// root_last set on the final one. a lone coefficient gives no result.
// one newton iteration runs 2*d+1 horner steps on one shared 24x24 multiplier
// (4 partial products per q24.24 product), then the bit-serial divider
// and the convergence check.
// i_coef is not ready from the last coefficient until the final root is
// handed to the output register. a stalled o_root holds its transaction;
// the solve runs on and waits only when the next root is ready to go out.
// configuration goes through the apb port: max_iterations at 0x00, tolerance at 0x08,
// start_value at 0x10, to be written by the user only while idle (not enforced).
// synchronous active-low reset empties the output and restores the
// register defaults; the coefficient stores are not cleared.
module polynomial_newton_root_finder_core #(
    parameter int MAX_DEGREE = pnr_pkg::DEF_MAX_DEGREE
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    pnr_coef_if.sink                   i_coef,
    pnr_root_if.source                 o_root,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pnr_pkg::ADDR_W-1:0] paddr,
    input  logic [pnr_pkg::DATA_W-1:0] pwdata,
    output logic [pnr_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import pnr_pkg::*;

    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int KW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_STEP = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    // configuration
    logic [IT_W-1:0]  r_max_it;
    logic [TOL_W-1:0] r_tol;
    t_q               r_start;

    // two banks, one holds the polynomial, the other takes the quotient
    t_q mem0 [DEPTH];
    t_q mem1 [DEPTH];
    t_q r_rd0, r_rd1;

    logic [2:0]      r_state;
    logic            r_sel;
    logic [CW-1:0]   r_cnt;
    logic [KW-1:0]   r_d;
    logic [KW-1:0]   r_k;
    logic            r_pass;
    logic [2:0]      r_ph;
    t_q              r_x0, r_x1, r_acc, r_r, r_m;
    logic [Q_W-1:0]  r_ma, r_mb;
    logic            r_neg;
    logic [Q_W-1:0]  r_prod;
    logic [Q_W+2:0]  r_sum;
    logic            r_big;
    logic [IT_W-1:0] r_it;
    logic            r_conv, r_fault;

    // output register
    logic            r_ov;
    t_q              r_root;
    logic [IT_W-1:0] r_used;
    logic            r_conv_o, r_fault_o, r_last_o;

    t_div_rsp w_div;
    logic     w_div_start;

    logic [FRAC_W-1:0] w_mul_a, w_mul_b;
    t_q                w_rd, w_acc_nx;
    logic              w_cfg_wr, w_in_acc, w_out_free;
    logic [CW-1:0]     w_cnt_nx, w_n;
    logic [IT_W-1:0]   w_limit;
    logic [Q_W:0]      w_step, w_step_mag;
    logic              w_we, w_wbank;
    logic [KW-1:0]     w_waddr;
    t_q                w_wdata;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_it <= RST_MAX_IT;
            r_tol    <= RST_TOL;
            r_start  <= '0;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:3])
                REG_MAX_IT: r_max_it <= pwdata[IT_W-1:0];
                REG_TOL:    r_tol    <= pwdata[TOL_W-1:0];
                REG_START:  r_start  <= pwdata[Q_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_MAX_IT: prdata = DATA_W'(r_max_it);
            REG_TOL:    prdata = DATA_W'(r_tol);
            REG_START:  prdata = {{(DATA_W-Q_W){r_start[Q_W-1]}}, r_start};
            default:    prdata = '0;
        endcase
    end

    // handshakes
    assign i_coef.ready = (r_state == S_LOAD);
    assign w_in_acc     = i_coef.valid && i_coef.ready;
    assign w_out_free   = !r_ov || o_root.ready;

    assign w_cnt_nx = (r_cnt < CW'(DEPTH)) ? r_cnt + 1'b1 : r_cnt;
    assign w_n      = w_cnt_nx - 1'b1;
    assign w_limit  = (r_max_it == '0) ? IT_W'(1) : r_max_it;

    // horner source: the polynomial bank in the first pass, the quotient in the second
    assign w_rd     = (r_pass ^ r_sel) ? r_rd1 : r_rd0;
    assign w_acc_nx = f_sat49({w_rd[Q_W-1], w_rd} + {r_m[Q_W-1], r_m});

    // shared 24x24 multiplier operand select by phase
    assign w_mul_a = (r_ph == 3'd2 || r_ph == 3'd4) ? r_ma[Q_W-1:FRAC_W] : r_ma[FRAC_W-1:0];
    assign w_mul_b = (r_ph == 3'd3 || r_ph == 3'd4) ? r_mb[Q_W-1:FRAC_W] : r_mb[FRAC_W-1:0];

    assign w_step     = {r_x1[Q_W-1], r_x1} - {r_x0[Q_W-1], r_x0};
    assign w_step_mag = w_step[Q_W] ? (Q_W+1)'(0) - w_step : w_step;

    // memory write port
    always_comb begin
        w_we    = 1'b0;
        w_wbank = r_sel;
        w_waddr = r_cnt[KW-1:0];
        w_wdata = i_coef.coefficient;
        if (w_in_acc && r_cnt < CW'(DEPTH)) begin
            w_we = 1'b1;
        end else if (r_state == S_STEP && r_ph == 3'd7 && !r_pass && r_k != '0) begin
            w_we    = 1'b1;
            w_wbank = !r_sel;
            w_waddr = r_k - 1'b1;
            w_wdata = w_acc_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we && !w_wbank) mem0[w_waddr] <= w_wdata;
        if (w_we && w_wbank)  mem1[w_waddr] <= w_wdata;
        r_rd0 <= mem0[r_k];
        r_rd1 <= mem1[r_k];
    end

    assign w_div_start = (r_state == S_STEP) && (r_ph == 3'd7) && r_pass && (r_k == '0)
                         && (w_acc_nx != '0);

    pnr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_r),
        .i_den   (w_acc_nx),
        .o_rsp   (w_div)
    );

    // product datapath, one partial product a phase
    always_ff @(posedge i_clk) begin
        if (r_state == S_STEP) begin
            unique case (r_ph)
                3'd0: begin
                    r_ma  <= f_mag(r_x0);
                    r_mb  <= f_mag(r_acc);
                    r_neg <= r_x0[Q_W-1] ^ r_acc[Q_W-1];
                end
                3'd1: r_prod <= w_mul_a * w_mul_b;
                3'd2: begin
                    // low partial product, rounded half away from zero on magnitude
                    r_sum  <= ({3'b0, r_prod} + (Q_W+3)'(1 << (FRAC_W-1))) >> FRAC_W;
                    r_prod <= w_mul_a * w_mul_b;
                end
                3'd3: begin
                    r_sum  <= r_sum + (Q_W+3)'(r_prod);
                    r_prod <= w_mul_a * w_mul_b;
                end
                3'd4: begin
                    r_sum  <= r_sum + (Q_W+3)'(r_prod);
                    r_prod <= w_mul_a * w_mul_b;
                end
                3'd5: begin
                    r_big <= |r_prod[Q_W-1:FRAC_W];
                    r_sum <= r_sum + {3'b0, r_prod[FRAC_W-1:0], {FRAC_W{1'b0}}};
                end
                3'd6: r_m <= r_big ? (r_neg ? MAXNEG : MAXPOS) : f_apply(r_sum, r_neg);
                3'd7: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_sel   <= 1'b0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            r_ph    <= '0;
            r_pass  <= 1'b0;
        end else begin
            if (o_root.ready && !(r_state == S_EMIT && w_out_free)) r_ov <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        r_cnt <= i_coef.coefficient_last ? '0 : w_cnt_nx;
                        if (i_coef.coefficient_last) begin
                            if (w_n != '0) begin
                                r_d     <= w_n[KW-1:0];
                                r_k     <= w_n[KW-1:0];
                                r_x0    <= r_start;
                                r_x1    <= r_start;
                                r_it    <= IT_W'(1);
                                r_conv  <= 1'b0;
                                r_fault <= 1'b0;
                                r_pass  <= 1'b0;
                                r_acc   <= '0;
                                r_ph    <= '0;
                                r_state <= S_STEP;
                            end
                        end
                    end
                end
                S_STEP: begin
                    r_ph <= r_ph + 1'b1;
                    if (r_ph == 3'd7) begin
                        if (r_k != '0) begin
                            r_acc <= w_acc_nx;
                            r_k   <= r_k - 1'b1;
                        end else if (!r_pass) begin
                            // remainder done, derivative pass over the quotient
                            r_r    <= w_acc_nx;
                            r_pass <= 1'b1;
                            r_k    <= r_d - 1'b1;
                            r_acc  <= '0;
                        end else if (w_acc_nx == '0) begin
                            // zero derivative ends this root at the current estimate
                            r_x1    <= r_x0;
                            r_fault <= 1'b1;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div.done) begin
                        r_x1    <= f_sat49({r_x0[Q_W-1], r_x0} - {w_div.quot[Q_W-1], w_div.quot});
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (w_step_mag < (Q_W+1)'(r_tol)) begin
                        r_conv  <= 1'b1;
                        r_state <= S_EMIT;
                    end else if (r_it == w_limit) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_x0    <= r_x1;
                        r_it    <= r_it + 1'b1;
                        r_pass  <= 1'b0;
                        r_k     <= r_d;
                        r_acc   <= '0;
                        r_ph    <= '0;
                        r_state <= S_STEP;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_ov      <= 1'b1;
                        r_root    <= r_x1;
                        r_used    <= r_it;
                        r_conv_o  <= r_conv;
                        r_fault_o <= r_fault;
                        r_last_o  <= (r_d == KW'(1));
                        // deflate: quotient bank becomes the polynomial
                        r_sel     <= !r_sel;
                        if (r_d == KW'(1)) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_d     <= r_d - 1'b1;
                            r_k     <= r_d - 1'b1;
                            r_x0    <= r_start;
                            r_x1    <= r_start;
                            r_it    <= IT_W'(1);
                            r_conv  <= 1'b0;
                            r_fault <= 1'b0;
                            r_pass  <= 1'b0;
                            r_acc   <= '0;
                            r_ph    <= '0;
                            r_state <= S_STEP;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_root.valid           = r_ov;
    assign o_root.root_value      = r_root;
    assign o_root.iterations_used = r_used;
    assign o_root.converged       = r_conv_o;
    assign o_root.divide_fault    = r_fault_o;
    assign o_root.root_last       = r_last_o;

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> (w_acc_nx != '0))
        else $error("divider started with zero derivative");
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_root.valid |-> !(o_root.converged && o_root.divide_fault))
        else $error("root both converged and faulted");
    a_used_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_root.valid |-> (o_root.iterations_used != '0))
        else $error("root with zero iterations");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("coefficient count beyond store depth");
`endif

endmodule
